// ===== rtl/core/hp_rk4_pkg.sv =====
`default_nettype none
package hp_rk4_pkg;

	localparam int AXES = 3;
	localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int DIV_STEPS = 5;
	localparam int CW = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_STEP        = 2'd2,
		OP_NONE        = 2'd3
	} opcode_t;

	localparam logic [1:0] REG_GAIN_FIRST  = 2'd0;
	localparam logic [1:0] REG_GAIN_SECOND = 2'd1;
	localparam logic [1:0] REG_TIME_STEP   = 2'd2;

	// state quantities, also the index of the matching derivative term
	localparam logic [1:0] Q_VEL1 = 2'd0;
	localparam logic [1:0] Q_VEL2 = 2'd1;
	localparam logic [1:0] Q_POS1 = 2'd2;
	localparam logic [1:0] Q_POS2 = 2'd3;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               hit;
	} sat_t;

	typedef struct packed {
		logic           capture;
		logic           load;
		logic           prep;
		logic           diff;
		logic           mul;
		logic           div_load;
		logic           div_step;
		logic           update;
		logic           out_load;
		logic [1:0]     stage;
		logic [1:0]     quant;
		logic [AXW-1:0] axis;
	} cmd_t;

	function automatic sat_t sat32(input logic signed [39:0] v);
		sat_t r;
		if (v > 40'sd2147483647) begin
			r.value = 32'sh7fffffff;
			r.hit = 1'b1;
		end else if (v < -40'sd2147483648) begin
			r.value = 32'sh80000000;
			r.hit = 1'b1;
		end else begin
			r.value = v[31:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/harmonic_pair_rk4_step_top.sv =====
// load item: passes through the load state, then the output state; unused opcode: goes straight to the output state
// step item: paced by one shared multiplier (four products per stage and axis,
//   12 passes) and the radix-256 divide-by-six unit (one state word at a time, 12 words)
// one item at a time; a finished result waits in the output register while the next
//   item is accepted
// arst_n clears state, gains and handshake at once; no clearing pass
`default_nettype none
module harmonic_pair_rk4_step_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire hp_rk4_pkg::in_item_t in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output hp_rk4_pkg::out_item_t     out_item,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);

	// command bundle from the sequencer to the datapath
	hp_rk4_pkg::cmd_t cmd;

	// sequencer: stage, axis and term counters, output valid
	hp_rk4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (in_item.opcode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: state words, derivative terms, accumulators, multiplier, divider
	hp_rk4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.out_item  (out_item)
	);

	// an accepted item always closes the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after item accept");

	// a new result only appears as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted while sequencer busy");

endmodule
`default_nettype wire

// ===== rtl/core/hp_rk4_ctrl.sv =====
`default_nettype none
module hp_rk4_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire hp_rk4_pkg::opcode_t opcode,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output hp_rk4_pkg::cmd_t         cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_LOAD  = 10'b0000000010,
		S_PREP  = 10'b0000000100,
		S_DIFF  = 10'b0000001000,
		S_MUL   = 10'b0000010000,
		S_DRAIN = 10'b0000100000,
		S_DIVLD = 10'b0001000000,
		S_DIV   = 10'b0010000000,
		S_UPD   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t                     state_q;
	logic [1:0]                 stage_q;
	logic [1:0]                 quant_q;
	logic [hp_rk4_pkg::AXW-1:0] axis_q;
	logic [hp_rk4_pkg::CW-1:0]  cnt_q;
	logic                       out_valid_q;
	logic                       axis_last;
	logic                       out_free;

	assign axis_last = (axis_q == hp_rk4_pkg::AXW'(hp_rk4_pkg::AXES - 1));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.stage = stage_q;
		cmd.quant = quant_q;
		cmd.axis = axis_q;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.load = (state_q == S_LOAD);
		cmd.prep = (state_q == S_PREP);
		cmd.diff = (state_q == S_DIFF);
		cmd.mul = (state_q == S_MUL);
		cmd.div_load = (state_q == S_DIVLD);
		cmd.div_step = (state_q == S_DIV);
		cmd.update = (state_q == S_UPD);
		cmd.out_load = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= '0;
			quant_q <= '0;
			axis_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					stage_q <= '0;
					quant_q <= '0;
					axis_q <= '0;
					if (in_valid) begin
						unique case (opcode)
							hp_rk4_pkg::OP_LOAD_FIRST,
							hp_rk4_pkg::OP_LOAD_SECOND: state_q <= S_LOAD;
							hp_rk4_pkg::OP_STEP: state_q <= S_PREP;
							hp_rk4_pkg::OP_NONE: state_q <= S_OUT;
						endcase
					end
				end
				S_LOAD: state_q <= S_OUT;
				S_PREP: state_q <= S_DIFF;
				S_DIFF: begin
					quant_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					quant_q <= quant_q + 2'd1;
					if (quant_q == 2'd3)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (axis_last) begin
						axis_q <= '0;
						if (stage_q == 2'd3) begin
							quant_q <= '0;
							state_q <= S_DIVLD;
						end else begin
							stage_q <= stage_q + 2'd1;
							state_q <= S_PREP;
						end
					end else begin
						axis_q <= axis_q + hp_rk4_pkg::AXW'(1);
						state_q <= S_PREP;
					end
				end
				S_DIVLD: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + hp_rk4_pkg::CW'(1);
					if (cnt_q == hp_rk4_pkg::CW'(hp_rk4_pkg::DIV_STEPS - 1))
						state_q <= S_UPD;
				end
				S_UPD: begin
					quant_q <= quant_q + 2'd1;
					if (quant_q == 2'd3) begin
						if (axis_last) begin
							state_q <= S_OUT;
						end else begin
							axis_q <= axis_q + hp_rk4_pkg::AXW'(1);
							state_q <= S_DIVLD;
						end
					end else begin
						state_q <= S_DIVLD;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hp_rk4_dp.sv =====
`default_nettype none
module hp_rk4_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire hp_rk4_pkg::in_item_t in_item,
	input  wire hp_rk4_pkg::cmd_t     cmd,
	output hp_rk4_pkg::out_item_t     out_item
);

	localparam int A = hp_rk4_pkg::AXES;

	logic [31:0] gain1_q, gain2_q, dt_q;

	logic signed [31:0] st_q  [4][A];
	logic signed [31:0] kp_q  [4][A];
	logic signed [35:0] acc_q [4][A];
	logic signed [31:0] inp_q [4];
	logic signed [31:0] d_q;
	logic signed [65:0] prod_s1;
	logic               post_vld_s1;
	logic [1:0]         post_quant_s1;
	logic [1:0]         post_stage_s1;
	logic [hp_rk4_pkg::AXW-1:0] post_axis_s1;
	logic [39:0]        div_q;
	logic [2:0]         rem_q;
	logic               flag_q;
	hp_rk4_pkg::in_item_t item_q;
	hp_rk4_pkg::out_item_t out_q;

	// stage inputs
	hp_rk4_pkg::sat_t   prep_sat [4];
	logic               prep_hit;
	always_comb begin
		logic signed [31:0] half;
		prep_hit = 1'b0;
		for (int j = 0; j < 4; j++) begin
			half = (cmd.stage == 2'd3) ? kp_q[j][cmd.axis] : (kp_q[j][cmd.axis] >>> 1);
			if (cmd.stage == 2'd0)
				half = '0;
			prep_sat[j] = hp_rk4_pkg::sat32(40'(st_q[j][cmd.axis]) + 40'(half));
			prep_hit = prep_hit | prep_sat[j].hit;
		end
	end

	hp_rk4_pkg::sat_t diff_sat;
	assign diff_sat = hp_rk4_pkg::sat32(40'(inp_q[hp_rk4_pkg::Q_POS1])
		- 40'(inp_q[hp_rk4_pkg::Q_POS2]));

	// multiplier operands
	logic signed [32:0] mul_a, mul_g;
	always_comb begin
		unique case (cmd.quant)
			hp_rk4_pkg::Q_VEL1: begin
				mul_a = 33'(d_q);
				mul_g = $signed({1'b0, gain1_q});
			end
			hp_rk4_pkg::Q_VEL2: begin
				mul_a = 33'(d_q);
				mul_g = $signed({1'b0, gain2_q});
			end
			hp_rk4_pkg::Q_POS1: begin
				mul_a = 33'(inp_q[hp_rk4_pkg::Q_VEL1]);
				mul_g = $signed({1'b0, dt_q});
			end
			default: begin
				mul_a = 33'(inp_q[hp_rk4_pkg::Q_VEL2]);
				mul_g = $signed({1'b0, dt_q});
			end
		endcase
	end

	// round, sign and clamp the product; double its weight in stages 1 and 2
	logic signed [65:0] psum;
	logic signed [39:0] rnd;
	hp_rk4_pkg::sat_t   post_sat;
	logic signed [35:0] kw;
	always_comb begin
		psum = prod_s1 + 66'sd2147483648;
		rnd = {{6{psum[65]}}, psum[65:32]};
		if (post_quant_s1 == hp_rk4_pkg::Q_VEL1)
			rnd = -rnd;
		post_sat = hp_rk4_pkg::sat32(rnd);
		kw = 36'(post_sat.value);
		if (post_stage_s1 == 2'd1 || post_stage_s1 == 2'd2)
			kw = kw <<< 1;
	end

	// eight quotient bits per cycle, remainder stays below six
	logic [39:0] div_n;
	logic [2:0]  rem_n;
	always_comb begin
		logic [3:0] t;
		div_n = div_q;
		rem_n = rem_q;
		for (int b = 0; b < 8; b++) begin
			t = {rem_n, div_n[39]};
			div_n = {div_n[38:0], (t >= 4'd6)};
			rem_n = (t >= 4'd6) ? 3'(t - 4'd6) : t[2:0];
		end
	end

	// quotient carries a bias of 2^32
	hp_rk4_pkg::sat_t upd_sat;
	assign upd_sat = hp_rk4_pkg::sat32(40'(st_q[cmd.quant][cmd.axis])
		+ $signed(div_q - 40'h0100000000));

	logic [1:0] lpos, lvel;
	assign lpos = (item_q.opcode == hp_rk4_pkg::OP_LOAD_FIRST) ? hp_rk4_pkg::Q_POS1
		: hp_rk4_pkg::Q_POS2;
	assign lvel = (item_q.opcode == hp_rk4_pkg::OP_LOAD_FIRST) ? hp_rk4_pkg::Q_VEL1
		: hp_rk4_pkg::Q_VEL2;

	function automatic logic signed [31:0] load_coord(input hp_rk4_pkg::in_item_t it,
		input int a);
		logic signed [31:0] r;
		unique case (a)
			0: r = it.load_x;
			1: r = it.load_y;
			default: r = it.load_z;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain1_q <= '0;
			gain2_q <= '0;
			dt_q <= '0;
			for (int j = 0; j < 4; j++)
				for (int a = 0; a < A; a++)
					st_q[j][a] <= '0;
			post_vld_s1 <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hp_rk4_pkg::REG_GAIN_FIRST: gain1_q <= cfg_data;
					hp_rk4_pkg::REG_GAIN_SECOND: gain2_q <= cfg_data;
					hp_rk4_pkg::REG_TIME_STEP: dt_q <= cfg_data;
					default: ;
				endcase
			end
			post_vld_s1 <= cmd.mul;
			if (cmd.capture)
				flag_q <= 1'b0;
			if (cmd.prep && prep_hit)
				flag_q <= 1'b1;
			if (cmd.diff && diff_sat.hit)
				flag_q <= 1'b1;
			if (post_vld_s1 && post_sat.hit)
				flag_q <= 1'b1;
			if (cmd.update && upd_sat.hit)
				flag_q <= 1'b1;
			if (cmd.load) begin
				for (int a = 0; a < A; a++) begin
					st_q[lpos][a] <= load_coord(item_q, a);
					st_q[lvel][a] <= '0;
				end
			end
			if (cmd.update)
				st_q[cmd.quant][cmd.axis] <= upd_sat.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
			for (int j = 0; j < 4; j++)
				for (int a = 0; a < A; a++)
					acc_q[j][a] <= '0;
		end
		if (cmd.prep)
			for (int j = 0; j < 4; j++)
				inp_q[j] <= prep_sat[j].value;
		if (cmd.diff)
			d_q <= diff_sat.value;
		if (cmd.mul) begin
			prod_s1 <= mul_a * mul_g;
			post_quant_s1 <= cmd.quant;
			post_stage_s1 <= cmd.stage;
			post_axis_s1 <= cmd.axis;
		end
		if (post_vld_s1) begin
			kp_q[post_quant_s1][post_axis_s1] <= post_sat.value;
			acc_q[post_quant_s1][post_axis_s1] <= acc_q[post_quant_s1][post_axis_s1] + kw;
		end
		if (cmd.div_load) begin
			div_q <= 40'(acc_q[cmd.quant][cmd.axis]) + 40'd3 + 40'd25769803776;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			div_q <= div_n;
			rem_q <= rem_n;
		end
		if (cmd.out_load) begin
			out_q.first_x <= st_q[hp_rk4_pkg::Q_POS1][0];
			out_q.second_x <= st_q[hp_rk4_pkg::Q_POS2][0];
			out_q.first_y <= (A > 1) ? st_q[hp_rk4_pkg::Q_POS1][(A > 1) ? 1 : 0] : '0;
			out_q.second_y <= (A > 1) ? st_q[hp_rk4_pkg::Q_POS2][(A > 1) ? 1 : 0] : '0;
			out_q.first_z <= (A > 2) ? st_q[hp_rk4_pkg::Q_POS1][(A > 2) ? 2 : 0] : '0;
			out_q.second_z <= (A > 2) ? st_q[hp_rk4_pkg::Q_POS2][(A > 2) ? 2 : 0] : '0;
			out_q.saturated <= (item_q.opcode == hp_rk4_pkg::OP_STEP) ? flag_q : 1'b0;
		end
	end

	assign out_item = out_q;

endmodule
`default_nettype wire
